/* src/tcc_pkg.sv */
`default_nettype none

package tcc_pkg;

    // Default size of the character store
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // Register reset values
    localparam logic [7:0] COLUMNS_RST = 8'd80;
    localparam logic [6:0] ROWS_RST    = 7'd30;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

    // Stream widths
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPW    = 1;
    localparam int QCW    = 2;

    typedef enum logic [1:0] {
        FN_PUT,
        FN_NEWLINE,
        FN_MOVE,
        FN_READ
    } func_t;

    // Classified command; positions are already clamped to the used area
    typedef struct packed {
        func_t      func;
        logic [7:0] ch;
        logic [6:0] px;
        logic [5:0] py;
    } cmd_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_RD_WAIT,
        B_SCR_RD,
        B_SCR_WR,
        B_FILL,
        B_DONE
    } bstate_t;

endpackage

`default_nettype wire

/* src/tcc_front.sv */
`default_nettype none

module tcc_front
    import tcc_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int NCW = $clog2(MAX_COLS) + 1,
    localparam int NRW = $clog2(MAX_ROWS) + 1
)
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic [NCW-1:0]       used_cols,
    input  logic [NRW-1:0]       used_rows,
    input  logic                 init_done,
    input  logic                 q_full,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    localparam int PXW = (NCW > 7) ? NCW : 7;
    localparam int PYW = (NRW > 6) ? NRW : 6;

    logic [PXW-1:0] px_w;
    logic [PXW-1:0] nc_w;
    logic [PXW-1:0] px_cl;
    logic [PYW-1:0] py_w;
    logic [PYW-1:0] nr_w;
    logic [PYW-1:0] py_cl;

    // Clamp positions against the used area
    always_comb
    begin
        px_w  = PXW'(s_tdata[14:8]);
        nc_w  = PXW'(used_cols);
        px_cl = (px_w >= nc_w) ? (nc_w - PXW'(1)) : px_w;
        py_w  = PYW'(s_tdata[20:15]);
        nr_w  = PYW'(used_rows);
        py_cl = (py_w >= nr_w) ? (nr_w - PYW'(1)) : py_w;
    end

    assign s_tready   = init_done && !q_full;
    assign q_push     = s_tvalid && s_tready;
    assign q_cmd.func = func_t'(s_tuser);
    assign q_cmd.ch   = s_tdata[7:0];
    assign q_cmd.px   = 7'(px_cl);
    assign q_cmd.py   = 6'(py_cl);

endmodule

`default_nettype wire

/* src/tcc_fifo.sv */
`default_nettype none

module tcc_fifo
    import tcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    cmd_t             q_mem [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QPW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;

    assign full     = (count_reg == QCW'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command queue underflow");

endmodule

`default_nettype wire

/* src/tcc_back.sv */
`default_nettype none

module tcc_back
    import tcc_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int NCW = $clog2(MAX_COLS) + 1,
    localparam int NRW = $clog2(MAX_ROWS) + 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [NCW-1:0]        used_cols,
    input  logic [NRW-1:0]        used_rows,
    input  logic                  q_empty,
    input  cmd_t                  q_cmd,
    output logic                  q_pop,
    output logic                  init_done,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    bstate_t        state_reg;
    bstate_t        state_next;

    logic [CW-1:0]  cur_col_reg;
    logic [CW-1:0]  cur_col_next;
    logic [RW-1:0]  cur_row_reg;
    logic [RW-1:0]  cur_row_next;
    logic [CW-1:0]  sc_col_reg;
    logic [CW-1:0]  sc_col_next;
    logic [RW-1:0]  sc_row_reg;
    logic [RW-1:0]  sc_row_next;
    logic [AW-1:0]  clr_addr_reg;
    logic [AW-1:0]  clr_addr_next;
    logic           scr_flag_reg;
    logic           scr_flag_next;
    logic [7:0]     cell_reg;
    logic [7:0]     cell_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [6:0]     out_col_reg;
    logic [5:0]     out_row_reg;
    logic [7:0]     out_cell_reg;
    logic           out_scr_reg;

    logic [7:0]     mem [DEPTH];
    logic [7:0]     rdata_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [AW-1:0]  mem_raddr;

    logic [CW-1:0]  cc;
    logic [RW-1:0]  cr;
    logic           col_end;
    logic           want_nl;
    logic           last_row;
    logic           scroll_go;
    logic           sc_row_end;
    logic           sc_last_src;
    logic           load_out;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                                input logic [RW-1:0] r);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    // Cursor clamped to the used area, and the decisions of a new line
    always_comb
    begin
        cc = (NCW'(cur_col_reg) >= used_cols) ? CW'(used_cols - NCW'(1)) : cur_col_reg;
        cr = (NRW'(cur_row_reg) >= used_rows) ? RW'(used_rows - NRW'(1)) : cur_row_reg;
        col_end     = (NCW'(cc) + NCW'(1)) >= used_cols;
        want_nl     = ((q_cmd.func == FN_PUT) && col_end) || (q_cmd.func == FN_NEWLINE);
        last_row    = !((NRW'(cr) + NRW'(1)) < used_rows);
        scroll_go   = want_nl && last_row;
        sc_row_end  = (NCW'(sc_col_reg) == (used_cols - NCW'(1)));
        sc_last_src = ((NRW'(sc_row_reg) + NRW'(2)) == used_rows);
        load_out    = (state_reg == B_DONE) && (!out_valid_reg || m_tready);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_cmd.func == FN_READ)
                    begin
                        state_next = B_RD_WAIT;
                    end
                    else if (scroll_go)
                    begin
                        state_next = (used_rows == NRW'(1)) ? B_FILL : B_SCR_RD;
                    end
                    else
                    begin
                        state_next = B_DONE;
                    end
                end
            end
            B_RD_WAIT:
            begin
                state_next = B_DONE;
            end
            B_SCR_RD:
            begin
                state_next = B_SCR_WR;
            end
            B_SCR_WR:
            begin
                state_next = (sc_row_end && sc_last_src) ? B_FILL : B_SCR_RD;
            end
            B_FILL:
            begin
                if (sc_row_end)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        cur_col_next  = cur_col_reg;
        cur_row_next  = cur_row_reg;
        sc_col_next   = sc_col_reg;
        sc_row_next   = sc_row_reg;
        clr_addr_next = clr_addr_reg;
        scr_flag_next = scr_flag_reg;
        cell_next     = cell_reg;
        q_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cell_addr(sc_col_reg, sc_row_reg);
        mem_wdata     = SPACE_CHAR;
        mem_raddr     = cell_addr(sc_col_reg, sc_row_reg + RW'(1));
        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    cell_next     = '0;
                    scr_flag_next = scroll_go;
                    sc_col_next   = '0;
                    sc_row_next   = '0;
                    cur_col_next  = cc;
                    cur_row_next  = cr;
                    case (q_cmd.func)
                        FN_PUT:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(cc, cr);
                            mem_wdata = q_cmd.ch;
                            cur_col_next = cc + CW'(1);
                        end
                        FN_MOVE:
                        begin
                            cur_col_next = CW'(q_cmd.px);
                            cur_row_next = RW'(q_cmd.py);
                        end
                        FN_READ:
                        begin
                            mem_raddr = cell_addr(CW'(q_cmd.px), RW'(q_cmd.py));
                        end
                        default:
                        begin
                        end
                    endcase
                    if (want_nl)
                    begin
                        cur_col_next = '0;
                        if (!last_row)
                        begin
                            cur_row_next = cr + RW'(1);
                        end
                    end
                end
            end
            B_RD_WAIT:
            begin
                cell_next = rdata_reg;
            end
            B_SCR_RD:
            begin
            end
            B_SCR_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                if (sc_row_end)
                begin
                    sc_col_next = '0;
                    if (!sc_last_src)
                    begin
                        sc_row_next = sc_row_reg + RW'(1);
                    end
                end
                else
                begin
                    sc_col_next = sc_col_reg + CW'(1);
                end
            end
            B_FILL:
            begin
                mem_we      = 1'b1;
                mem_waddr   = cell_addr(sc_col_reg, RW'(used_rows - NRW'(1)));
                sc_col_next = sc_col_reg + CW'(1);
            end
            B_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            sc_col_reg    <= '0;
            sc_row_reg    <= '0;
            clr_addr_reg  <= '0;
            scr_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            sc_col_reg    <= sc_col_next;
            sc_row_reg    <= sc_row_next;
            clr_addr_reg  <= clr_addr_next;
            scr_flag_reg  <= scr_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
        if (load_out)
        begin
            out_col_reg  <= 7'(cur_col_reg);
            out_row_reg  <= 6'(cur_row_reg);
            out_cell_reg <= cell_reg;
            out_scr_reg  <= scr_flag_reg;
        end
    end

    // Character store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign init_done = (state_reg != B_CLEAR);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_scr_reg, out_cell_reg, out_row_reg, out_col_reg};

    a_cursor_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> ((NCW'(cur_col_reg) < used_cols) && (NRW'(cur_row_reg) < used_rows)))
        else $error("cursor outside used area at result");

    a_read_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_RD_WAIT) |-> ($past(state_reg) == B_IDLE))
        else $error("read wait not entered from idle");

    a_scroll_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_scr_reg) |-> (out_col_reg == '0))
        else $error("scroll result with nonzero column");

endmodule

`default_nettype wire

/* src/text_console_cursor_scroll_unit.sv */
`default_nettype none

// Text console with cursor and upward scroll. Commands arrive on the s_ stream
// (tuser = function: put character, new line, move cursor, read cell) and each
// returns exactly one result on the m_ stream with the cursor after the command,
// the cell read (zero unless a read) and a scroll flag. Size registers columns
// and rows are written through the cfg port; the user must write them only while
// the unit is idle, as the block does not enforce it. Values out of range act as
// the nearest of 1..MAX_COLS / 1..MAX_ROWS. After reset a clearing pass fills all
// MAX_COLS*MAX_ROWS cells with spaces, one per cycle (8192 cells at the defaults);
// s_tready stays low until it completes. The store has one write port and one
// registered read port. A read adds a wait state; a scroll copies each cell up one
// row through a read and a write state, then fills the last row with spaces.
// A two-entry command queue lets the front accept while the back is busy.

module text_console_cursor_scroll_unit
    import tcc_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // command stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // char_code[7:0], pos_x[14:8], pos_y[20:15]
    input  logic [1:0]            s_tuser,   // func[1:0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // cursor_col[6:0], cursor_row[12:7],
                                             // cell_char[20:13], scrolled[21]
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]            cfg_data
);

    localparam int NCW = $clog2(MAX_COLS) + 1;
    localparam int NRW = $clog2(MAX_ROWS) + 1;
    localparam int XW  = (NCW > 8) ? NCW : 8;
    localparam int YW  = (NRW > 7) ? NRW : 7;

    logic [7:0]     columns_reg;
    logic [7:0]     columns_next;
    logic [6:0]     rows_reg;
    logic [6:0]     rows_next;
    logic [NCW-1:0] used_cols;
    logic [NRW-1:0] used_rows;

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    cmd_t           push_cmd;
    cmd_t           head_cmd;
    logic           init_done;

    // Register file: always ready; the user must write it only while idle, as the block does not enforce it
    assign cfg_ready = 1'b1;

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COLUMNS: columns_next = cfg_data;
                REG_ROWS:    rows_next    = cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RST;
            rows_reg    <= ROWS_RST;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
        end
    end

    // Size in use: zero acts as one, oversize as the store limit
    always_comb
    begin
        if (columns_reg == '0)
        begin
            used_cols = NCW'(1);
        end
        else if (XW'(columns_reg) > XW'(MAX_COLS))
        begin
            used_cols = NCW'(MAX_COLS);
        end
        else
        begin
            used_cols = NCW'(columns_reg);
        end

        if (rows_reg == '0)
        begin
            used_rows = NRW'(1);
        end
        else if (YW'(rows_reg) > YW'(MAX_ROWS))
        begin
            used_rows = NRW'(MAX_ROWS);
        end
        else
        begin
            used_rows = NRW'(rows_reg);
        end
    end

    // Front: accept and clamp command positions
    tcc_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .used_cols (used_cols),
        .used_rows (used_rows),
        .init_done (init_done),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    // Command queue
    tcc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back: cursor, character store, scroll sequencer, result register
    tcc_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .used_cols (used_cols),
        .used_rows (used_rows),
        .q_empty   (q_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
